>>> rtl/tltt_pkg.sv
// Shared types, widths and helpers for the thick line to triangles unit.
package tltt_pkg;

    // Field widths.
    localparam int COORD_W = 20;
    localparam int WIDTH_W = 12;
    localparam int RGBA_W  = 32;

    // Derived arithmetic widths.
    localparam int DIFF_W  = COORD_W + 1;          // signed segment delta
    localparam int MAG_W   = COORD_W;              // |delta| fits in COORD_W bits
    localparam int SQ_W    = 2 * MAG_W;            // one squared component
    localparam int SUM_W   = SQ_W + 1;             // squared length
    localparam int PROD_W  = MAG_W + WIDTH_W;      // |delta| * width
    localparam int LEN_FRAC = 11;                  // extra fraction bits of the length
    localparam int RAD_PAD = 2 * LEN_FRAC;         // radicand is the sum shifted up
    localparam int RAD_W   = SUM_W + RAD_PAD + 1;  // padded to an even width
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int ROOT_W  = SQRT_STEPS;
    localparam int SREM_W  = ROOT_W + 1;
    localparam int NUM_SHIFT = LEN_FRAC;           // 2 * 1024 on the product
    localparam int NUM_W   = PROD_W + NUM_SHIFT + 1;
    localparam int DEN_W   = ROOT_W + 1;
    localparam int QUO_W   = 12;                   // offset magnitude never exceeds 2048
    localparam int DIV_STEPS = QUO_W;
    localparam int DREM_W  = DEN_W;
    localparam int OFS_W   = QUO_W + 1;
    localparam int CSUM_W  = COORD_W + 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic        [MAG_W-1:0]   mag_t;
    typedef logic        [WIDTH_W-1:0] width_t;
    typedef logic        [RGBA_W-1:0]  rgba_t;
    typedef logic        [SQ_W-1:0]    sq_t;
    typedef logic        [SUM_W-1:0]   sum_t;
    typedef logic        [PROD_W-1:0]  prod_t;
    typedef logic        [RAD_W-1:0]   rad_t;
    typedef logic        [ROOT_W-1:0]  root_t;
    typedef logic        [SREM_W-1:0]  srem_t;
    typedef logic        [SREM_W+1:0]  sstep_t;
    typedef logic        [NUM_W-1:0]   num_t;
    typedef logic        [DEN_W-1:0]   den_t;
    typedef logic        [QUO_W-1:0]   quo_t;
    typedef logic        [DREM_W-1:0]  drem_t;
    typedef logic        [DREM_W:0]    dstep_t;
    typedef logic signed [OFS_W-1:0]   ofs_t;
    typedef logic signed [CSUM_W-1:0]  csum_t;

    // Segment data that rides along the whole pipeline.
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        rgba_t  rgba;
        logic   neg_ox;
        logic   neg_oy;
    } carry_t;

    typedef struct packed {
        carry_t c;
        mag_t   adx;
        mag_t   ady;
        width_t w;
    } stage_a_t;

    typedef struct packed {
        carry_t c;
        sq_t    sq_x;
        sq_t    sq_y;
        prod_t  num_ox;
        prod_t  num_oy;
    } stage_b_t;

    typedef struct packed {
        carry_t c;
        prod_t  num_ox;
        prod_t  num_oy;
        sum_t   sum;
        srem_t  rem;
        root_t  root;
    } sqrt_stage_t;

    typedef struct packed {
        carry_t c;
        den_t   den;
        quo_t   nlo_x;
        quo_t   nlo_y;
        drem_t  rem_x;
        drem_t  rem_y;
        quo_t   q_x;
        quo_t   q_y;
    } div_stage_t;

    // The four distinct corners of the quad plus the color.
    typedef struct packed {
        coord_t ap_x;
        coord_t ap_y;
        coord_t bp_x;
        coord_t bp_y;
        coord_t bm_x;
        coord_t bm_y;
        coord_t am_x;
        coord_t am_y;
        rgba_t  rgba;
    } corners_t;

    // Which vertex of the two triangles is on the output.
    typedef enum logic [2:0] {
        VTX_AP_FIRST,
        VTX_BP,
        VTX_BM_FIRST,
        VTX_AP_SECOND,
        VTX_BM_SECOND,
        VTX_AM
    } vtx_sel_t;

    // Clamp a coordinate that may have grown by one bit to the field range.
    function automatic coord_t sat_coord(input csum_t v);
        coord_t r;
        if (v[CSUM_W-1] != v[CSUM_W-2]) begin
            r = v[CSUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/thick_line_to_triangles_unit.sv
// Thick line segment to two triangles: pipelined offset computation and vertex sequencer.
// The first vertex of a segment is offered once its word has passed stages A and B, the
// square root and divider stages and the sequencer register; the other five follow on
// consecutive cycles when the sink keeps m_ready high. The segment rate is set by the
// single vertex output; the pipeline takes a word every cycle unless the sequencer is full.
// Reset: aresetn is synchronous and active low; it empties every pipeline stage and the
// sequencer, and the block is ready to take a word in the first cycle after reset.
module thick_line_to_triangles_unit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  tltt_pkg::coord_t         s_start_x,
    input  tltt_pkg::coord_t         s_start_y,
    input  tltt_pkg::coord_t         s_end_x,
    input  tltt_pkg::coord_t         s_end_y,
    input  tltt_pkg::width_t         s_width,
    input  tltt_pkg::rgba_t          s_rgba,
    output logic                     m_valid,
    input  logic                     m_ready,
    output tltt_pkg::coord_t         m_vertex_x,
    output tltt_pkg::coord_t         m_vertex_y,
    output tltt_pkg::rgba_t          m_vertex_rgba,
    output logic                     m_final_vertex
);

    // The whole pipeline moves on one enable. It advances whenever its last stage is
    // empty or the vertex sequencer is about to take that stage's segment.
    logic pipe_en;
    logic ex_load_ok;
    logic ex_load;
    logic ex_take;

    // ------------------------------------------------------------------------
    // Stage A: segment delta, its magnitudes and the signs of the offset.
    // A zero-length segment gets no valid bit here, so it never produces vertices.
    // ------------------------------------------------------------------------
    tltt_pkg::diff_t    dx, dy, adx_full, ady_full;
    logic               seg_zero;
    tltt_pkg::stage_a_t a_next, a_reg;
    logic               a_valid_reg;

    always_comb begin
        dx = tltt_pkg::diff_t'(s_end_x) - tltt_pkg::diff_t'(s_start_x);
        dy = tltt_pkg::diff_t'(s_end_y) - tltt_pkg::diff_t'(s_start_y);
        adx_full = dx[tltt_pkg::DIFF_W-1] ? -dx : dx;
        ady_full = dy[tltt_pkg::DIFF_W-1] ? -dy : dy;
        seg_zero = (dx == '0) && (dy == '0);

        a_next.c.ax     = s_start_x;
        a_next.c.ay     = s_start_y;
        a_next.c.bx     = s_end_x;
        a_next.c.by     = s_end_y;
        a_next.c.rgba   = s_rgba;
        // The offset is the left normal: x goes against dy, y goes with dx.
        a_next.c.neg_ox = !dy[tltt_pkg::DIFF_W-1] && (dy != '0);
        a_next.c.neg_oy = dx[tltt_pkg::DIFF_W-1];
        a_next.adx      = adx_full[tltt_pkg::MAG_W-1:0];
        a_next.ady      = ady_full[tltt_pkg::MAG_W-1:0];
        a_next.w        = s_width;
    end

    // ------------------------------------------------------------------------
    // Stage B: squares of the delta and the products |delta| * width.
    // ------------------------------------------------------------------------
    tltt_pkg::stage_b_t b_next, b_reg;
    logic               b_valid_reg;

    always_comb begin
        b_next.c      = a_reg.c;
        b_next.sq_x   = tltt_pkg::sq_t'(a_reg.adx) * tltt_pkg::sq_t'(a_reg.adx);
        b_next.sq_y   = tltt_pkg::sq_t'(a_reg.ady) * tltt_pkg::sq_t'(a_reg.ady);
        b_next.num_ox = tltt_pkg::prod_t'(a_reg.ady) * tltt_pkg::prod_t'(a_reg.w);
        b_next.num_oy = tltt_pkg::prod_t'(a_reg.adx) * tltt_pkg::prod_t'(a_reg.w);
    end

    // ------------------------------------------------------------------------
    // Square root of the squared length, shifted up so the root carries 11 extra
    // fraction bits. Entry 0 holds the sum; each later entry has one more root bit,
    // found by the usual digit-by-digit method with one trial subtract per stage.
    // ------------------------------------------------------------------------
    tltt_pkg::sqrt_stage_t sq_next [tltt_pkg::SQRT_STEPS+1];
    tltt_pkg::sqrt_stage_t sq_reg  [tltt_pkg::SQRT_STEPS+1];
    logic [tltt_pkg::SQRT_STEPS:0] sq_valid_reg;

    always_comb begin
        sq_next[0].c      = b_reg.c;
        sq_next[0].num_ox = b_reg.num_ox;
        sq_next[0].num_oy = b_reg.num_oy;
        sq_next[0].sum    = tltt_pkg::sum_t'(b_reg.sq_x) + tltt_pkg::sum_t'(b_reg.sq_y);
        sq_next[0].rem    = '0;
        sq_next[0].root   = '0;
    end

    for (genvar k = 0; k < tltt_pkg::SQRT_STEPS; k++) begin : g_sqrt
        tltt_pkg::rad_t   rad;
        tltt_pkg::sstep_t shifted;
        tltt_pkg::sstep_t trial;
        tltt_pkg::sstep_t diff;
        logic             ge;

        always_comb begin
            rad     = {1'b0, sq_reg[k].sum, {tltt_pkg::RAD_PAD{1'b0}}};
            shifted = {sq_reg[k].rem, rad[tltt_pkg::RAD_W-1-2*k -: 2]};
            trial   = tltt_pkg::sstep_t'({sq_reg[k].root, 2'b01});
            diff    = shifted - trial;
            ge      = (shifted >= trial);

            sq_next[k+1]      = sq_reg[k];
            sq_next[k+1].rem  = ge ? diff[tltt_pkg::SREM_W-1:0]
                                   : shifted[tltt_pkg::SREM_W-1:0];
            sq_next[k+1].root = {sq_reg[k].root[tltt_pkg::ROOT_W-2:0], ge};
        end
    end

    // ------------------------------------------------------------------------
    // Rounded division. With L the scaled length, each offset magnitude is
    // floor((2 * num * 1024 + L) / (2 * L)). Entry 0 forms both numerators and the
    // shared divisor; each later entry produces one quotient bit for both offsets.
    // ------------------------------------------------------------------------
    tltt_pkg::div_stage_t dv_next [tltt_pkg::DIV_STEPS+1];
    tltt_pkg::div_stage_t dv_reg  [tltt_pkg::DIV_STEPS+1];
    logic [tltt_pkg::DIV_STEPS:0] dv_valid_reg;
    tltt_pkg::num_t       n_x, n_y;

    always_comb begin
        n_x = (tltt_pkg::num_t'(sq_reg[tltt_pkg::SQRT_STEPS].num_ox) << tltt_pkg::NUM_SHIFT)
            + tltt_pkg::num_t'(sq_reg[tltt_pkg::SQRT_STEPS].root);
        n_y = (tltt_pkg::num_t'(sq_reg[tltt_pkg::SQRT_STEPS].num_oy) << tltt_pkg::NUM_SHIFT)
            + tltt_pkg::num_t'(sq_reg[tltt_pkg::SQRT_STEPS].root);

        dv_next[0].c     = sq_reg[tltt_pkg::SQRT_STEPS].c;
        dv_next[0].den   = {sq_reg[tltt_pkg::SQRT_STEPS].root, 1'b0};
        // The upper numerator bits are always below the divisor, since the
        // quotient fits in QUO_W bits.
        dv_next[0].rem_x = tltt_pkg::drem_t'(n_x[tltt_pkg::NUM_W-1:tltt_pkg::QUO_W]);
        dv_next[0].rem_y = tltt_pkg::drem_t'(n_y[tltt_pkg::NUM_W-1:tltt_pkg::QUO_W]);
        dv_next[0].nlo_x = n_x[tltt_pkg::QUO_W-1:0];
        dv_next[0].nlo_y = n_y[tltt_pkg::QUO_W-1:0];
        dv_next[0].q_x   = '0;
        dv_next[0].q_y   = '0;
    end

    for (genvar k = 0; k < tltt_pkg::DIV_STEPS; k++) begin : g_div
        tltt_pkg::dstep_t sh_x, sh_y, den_ext, diff_x, diff_y;
        logic             ge_x, ge_y;

        always_comb begin
            sh_x    = {dv_reg[k].rem_x, dv_reg[k].nlo_x[tltt_pkg::QUO_W-1-k]};
            sh_y    = {dv_reg[k].rem_y, dv_reg[k].nlo_y[tltt_pkg::QUO_W-1-k]};
            den_ext = {1'b0, dv_reg[k].den};
            diff_x  = sh_x - den_ext;
            diff_y  = sh_y - den_ext;
            ge_x    = (sh_x >= den_ext);
            ge_y    = (sh_y >= den_ext);

            dv_next[k+1]       = dv_reg[k];
            dv_next[k+1].rem_x = ge_x ? diff_x[tltt_pkg::DREM_W-1:0]
                                      : sh_x[tltt_pkg::DREM_W-1:0];
            dv_next[k+1].rem_y = ge_y ? diff_y[tltt_pkg::DREM_W-1:0]
                                      : sh_y[tltt_pkg::DREM_W-1:0];
            dv_next[k+1].q_x   = {dv_reg[k].q_x[tltt_pkg::QUO_W-2:0], ge_x};
            dv_next[k+1].q_y   = {dv_reg[k].q_y[tltt_pkg::QUO_W-2:0], ge_y};
        end
    end

    // ------------------------------------------------------------------------
    // Corner computation: apply the offset signs and saturate the four corners.
    // It feeds the vertex sequencer directly from the last divider stage.
    // ------------------------------------------------------------------------
    tltt_pkg::div_stage_t dv_last;
    tltt_pkg::ofs_t       ox_mag, oy_mag, ox, oy;
    tltt_pkg::corners_t   ex_next, ex_reg;

    always_comb begin
        dv_last = dv_reg[tltt_pkg::DIV_STEPS];
        ox_mag  = tltt_pkg::ofs_t'(dv_last.q_x);
        oy_mag  = tltt_pkg::ofs_t'(dv_last.q_y);
        ox      = dv_last.c.neg_ox ? -ox_mag : ox_mag;
        oy      = dv_last.c.neg_oy ? -oy_mag : oy_mag;

        ex_next.ap_x = tltt_pkg::sat_coord(tltt_pkg::csum_t'(dv_last.c.ax) + tltt_pkg::csum_t'(ox));
        ex_next.ap_y = tltt_pkg::sat_coord(tltt_pkg::csum_t'(dv_last.c.ay) + tltt_pkg::csum_t'(oy));
        ex_next.bp_x = tltt_pkg::sat_coord(tltt_pkg::csum_t'(dv_last.c.bx) + tltt_pkg::csum_t'(ox));
        ex_next.bp_y = tltt_pkg::sat_coord(tltt_pkg::csum_t'(dv_last.c.by) + tltt_pkg::csum_t'(oy));
        ex_next.bm_x = tltt_pkg::sat_coord(tltt_pkg::csum_t'(dv_last.c.bx) - tltt_pkg::csum_t'(ox));
        ex_next.bm_y = tltt_pkg::sat_coord(tltt_pkg::csum_t'(dv_last.c.by) - tltt_pkg::csum_t'(oy));
        ex_next.am_x = tltt_pkg::sat_coord(tltt_pkg::csum_t'(dv_last.c.ax) - tltt_pkg::csum_t'(ox));
        ex_next.am_y = tltt_pkg::sat_coord(tltt_pkg::csum_t'(dv_last.c.ay) - tltt_pkg::csum_t'(oy));
        ex_next.rgba = dv_last.c.rgba;
    end

    // ------------------------------------------------------------------------
    // Vertex sequencer. It holds one segment's corners and walks the six vertices.
    // A segment waiting in the last divider stage loads in the same cycle the sixth vertex is
    // taken, so the output stays busy without a gap.
    // ------------------------------------------------------------------------
    logic               ex_busy_reg, ex_busy_next;
    tltt_pkg::vtx_sel_t ex_sel_reg, ex_sel_next;

    assign ex_take    = ex_busy_reg && m_ready;
    assign ex_load_ok = !ex_busy_reg || (m_ready && (ex_sel_reg == tltt_pkg::VTX_AM));
    assign ex_load    = dv_valid_reg[tltt_pkg::DIV_STEPS] && ex_load_ok;
    assign pipe_en    = !dv_valid_reg[tltt_pkg::DIV_STEPS] || ex_load_ok;
    assign s_ready    = pipe_en;

    // Next state.
    always_comb begin
        ex_busy_next = ex_busy_reg;
        ex_sel_next  = ex_sel_reg;
        if (ex_load) begin
            ex_busy_next = 1'b1;
            ex_sel_next  = tltt_pkg::VTX_AP_FIRST;
        end else if (ex_take) begin
            unique case (ex_sel_reg)
                tltt_pkg::VTX_AP_FIRST:  ex_sel_next = tltt_pkg::VTX_BP;
                tltt_pkg::VTX_BP:        ex_sel_next = tltt_pkg::VTX_BM_FIRST;
                tltt_pkg::VTX_BM_FIRST:  ex_sel_next = tltt_pkg::VTX_AP_SECOND;
                tltt_pkg::VTX_AP_SECOND: ex_sel_next = tltt_pkg::VTX_BM_SECOND;
                tltt_pkg::VTX_BM_SECOND: ex_sel_next = tltt_pkg::VTX_AM;
                tltt_pkg::VTX_AM:        ex_busy_next = 1'b0;
                default:                 ex_busy_next = 1'b0;
            endcase
        end
    end

    // Outputs.
    always_comb begin
        m_valid        = ex_busy_reg;
        m_vertex_rgba  = ex_reg.rgba;
        m_final_vertex = (ex_sel_reg == tltt_pkg::VTX_AM);
        unique case (ex_sel_reg)
            tltt_pkg::VTX_AP_FIRST,
            tltt_pkg::VTX_AP_SECOND: begin
                m_vertex_x = ex_reg.ap_x;
                m_vertex_y = ex_reg.ap_y;
            end
            tltt_pkg::VTX_BP: begin
                m_vertex_x = ex_reg.bp_x;
                m_vertex_y = ex_reg.bp_y;
            end
            tltt_pkg::VTX_BM_FIRST,
            tltt_pkg::VTX_BM_SECOND: begin
                m_vertex_x = ex_reg.bm_x;
                m_vertex_y = ex_reg.bm_y;
            end
            tltt_pkg::VTX_AM: begin
                m_vertex_x = ex_reg.am_x;
                m_vertex_y = ex_reg.am_y;
            end
            default: begin
                m_vertex_x = ex_reg.ap_x;
                m_vertex_y = ex_reg.ap_y;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Registers. Valid bits and sequencer state are reset; the data path is not.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            sq_valid_reg <= '0;
            dv_valid_reg <= '0;
            ex_busy_reg  <= 1'b0;
            ex_sel_reg   <= tltt_pkg::VTX_AP_FIRST;
        end else begin
            if (pipe_en) begin
                a_valid_reg  <= s_valid && !seg_zero;
                b_valid_reg  <= a_valid_reg;
                sq_valid_reg <= {sq_valid_reg[tltt_pkg::SQRT_STEPS-1:0], b_valid_reg};
                dv_valid_reg <= {dv_valid_reg[tltt_pkg::DIV_STEPS-1:0],
                                 sq_valid_reg[tltt_pkg::SQRT_STEPS]};
            end
            ex_busy_reg <= ex_busy_next;
            ex_sel_reg  <= ex_sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            sq_reg <= sq_next;
            dv_reg <= dv_next;
        end
        if (ex_load) begin
            ex_reg <= ex_next;
        end
    end

endmodule
